/* hdl/zst_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package zst_pkg;
	localparam int DEF_MAX_WIDTH = 640;
	localparam int DEF_MAX_HEIGHT = 480;
	localparam logic [9:0] RST_WIDTH = 10'd640;
	localparam logic [8:0] RST_HEIGHT = 9'd480;
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_READ = 1'b1;
	localparam logic REG_WIDTH = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic write_px;   // store pixel_white at the raster position
		logic read_px;    // issue a read of the raster position
		logic pos_clear;  // raster position to zero
		logic pos_inc;    // raster position plus one
		logic scan_start; // begin one sub-pass
		logic second;     // which sub-pass
	} zst_cmd_t;

	// Status from the datapath.
	typedef struct packed {
		logic pos_last;   // raster position is the last pixel
		logic scan_done;  // sub-pass finished this cycle
		logic scan_any;   // sub-pass cleared a pixel
		logic small_img;  // no interior pixel
	} zst_sts_t;

	// Zhang-Suen removal test; n holds P2..P9 in bits 0..7.
	function automatic logic zs_remove(input logic [7:0] n, input logic second);
		logic [3:0] trans;
		logic [3:0] whites;
		logic a;
		logic b;
		trans = '0;
		whites = '0;
		for (int i = 0; i < 8; i++) begin
			trans = trans + 4'(!n[i] && n[(i + 1) % 8]);
			whites = whites + 4'(n[i]);
		end
		if (!second) begin
			a = n[0] & n[2] & n[4];
			b = n[2] & n[4] & n[6];
		end else begin
			a = n[0] & n[2] & n[6];
			b = n[0] & n[4] & n[6];
		end
		return (trans == 4'd1) && (whites >= 4'd2) && (whites <= 4'd6) && !a && !b;
	endfunction
endpackage
`default_nettype wire

/* hdl/zst_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
module zst_datapath import zst_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [9:0] image_width,
	input wire logic [8:0] image_height,
	input wire logic pixel_white,
	input wire zst_cmd_t cmd,
	output zst_sts_t sts,
	output logic skeleton_pixel
);
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW = $clog2(DEPTH);
	localparam int XW = $clog2(MAX_WIDTH + 1);
	localparam int YW = $clog2(MAX_HEIGHT + 1);
	localparam int CW = $clog2(MAX_WIDTH);

	// Sub-pass sequencer phases, one frame memory access per cycle.
	typedef enum logic [3:0] {
		SC_IDLE, SC_CPY_RD, SC_CPY_WR, SC_RD_MID, SC_RD_DN, SC_WAIT, SC_EVAL, SC_DONE
	} sc_t;

	logic frame_mem [DEPTH];
	logic rowa_mem [MAX_WIDTH]; // unmodified row above
	logic [XW-1:0] w_eff;
	logic [YW-1:0] h_eff;
	logic [AW-1:0] total_m1;
	logic [AW-1:0] pos_q;
	logic [AW-1:0] addr;
	logic mem_we;
	logic mem_wd;
	logic mem_rd_q;
	logic [AW-1:0] row_base_q;
	logic [CW-1:0] col_q;
	logic [YW-1:0] row_q;
	sc_t sc_q;
	logic [2:0] win_up_q, win_mid_q, win_dn_q;
	logic [1:0] k_q;
	logic any_q;
	logic second_q;
	logic row_up_rd_q;
	logic rem;

	always_comb begin
		if (image_width == '0) w_eff = XW'(1);
		else if (32'(image_width) > MAX_WIDTH) w_eff = XW'(MAX_WIDTH);
		else w_eff = XW'(image_width);
		if (image_height == '0) h_eff = YW'(1);
		else if (32'(image_height) > MAX_HEIGHT) h_eff = YW'(MAX_HEIGHT);
		else h_eff = YW'(image_height);
	end

	// Product of effective sizes less one; combinational, it follows a register write in the cycle after.
	assign total_m1 = AW'(w_eff * h_eff - 1);

	assign sts.pos_last = (pos_q == total_m1);
	assign sts.small_img = (w_eff < XW'(3)) || (h_eff < YW'(3));
	assign sts.scan_done = (sc_q == SC_DONE);
	assign sts.scan_any = any_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (cmd.pos_clear) begin
			pos_q <= '0;
		end else if (cmd.pos_inc) begin
			pos_q <= pos_q + AW'(1);
		end
	end

	assign rem = win_mid_q[1] && zs_remove({win_up_q[0], win_mid_q[0], win_dn_q[0],
		win_dn_q[1], win_dn_q[2], win_mid_q[2], win_up_q[2], win_up_q[1]}, second_q);

	// Memory address and write selection.
	always_comb begin
		addr = pos_q;
		mem_we = 1'b0;
		mem_wd = pixel_white;
		if (cmd.write_px) begin
			mem_we = 1'b1;
		end else begin
			case (sc_q)
				SC_CPY_RD: addr = AW'(col_q);
				SC_RD_MID: addr = row_base_q + AW'(col_q);
				SC_RD_DN: addr = row_base_q + AW'(w_eff) + AW'(col_q);
				SC_EVAL: begin
					addr = row_base_q + AW'(col_q) - AW'(1);
					mem_we = rem;
					mem_wd = 1'b0;
				end
				default: addr = pos_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) frame_mem[addr] <= mem_wd;
		mem_rd_q <= frame_mem[addr];
	end
	assign skeleton_pixel = mem_rd_q;

	// Row history: the old value above is read while the unmodified middle
	// pixel of the same column takes its place.
	always_ff @(posedge clk) begin
		row_up_rd_q <= rowa_mem[col_q];
		if ((sc_q == SC_CPY_WR) || (sc_q == SC_RD_DN)) rowa_mem[col_q] <= mem_rd_q;
	end

	// Scanner. For column col_q it reads middle and below from the frame and
	// above from row history, then shifts the 3x3 window and judges col_q-1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_q <= SC_IDLE;
			col_q <= '0;
			row_q <= '0;
			row_base_q <= '0;
			any_q <= 1'b0;
			second_q <= 1'b0;
			k_q <= '0;
			win_up_q <= '0;
			win_mid_q <= '0;
			win_dn_q <= '0;
		end else begin
			case (sc_q)
				SC_IDLE: begin
					if (cmd.scan_start) begin
						second_q <= cmd.second;
						any_q <= 1'b0;
						col_q <= '0;
						sc_q <= SC_CPY_RD;
					end
				end
				SC_CPY_RD: sc_q <= SC_CPY_WR;
				SC_CPY_WR: begin
					if (XW'(col_q) == w_eff - XW'(1)) begin
						col_q <= '0;
						row_q <= YW'(1);
						row_base_q <= AW'(w_eff);
						k_q <= '0;
						sc_q <= SC_RD_MID;
					end else begin
						col_q <= col_q + CW'(1);
						sc_q <= SC_CPY_RD;
					end
				end
				SC_RD_MID: sc_q <= SC_RD_DN;
				SC_RD_DN: begin
					win_mid_q <= {mem_rd_q, win_mid_q[2:1]};
					sc_q <= SC_WAIT;
				end
				// The first two columns of a row only fill the window.
				SC_WAIT: begin
					win_up_q <= {row_up_rd_q, win_up_q[2:1]};
					win_dn_q <= {mem_rd_q, win_dn_q[2:1]};
					if (k_q != 2'd2) begin
						k_q <= k_q + 2'd1;
						col_q <= col_q + CW'(1);
						sc_q <= SC_RD_MID;
					end else begin
						sc_q <= SC_EVAL;
					end
				end
				SC_EVAL: begin
					if (rem) any_q <= 1'b1;
					if (XW'(col_q) == w_eff - XW'(1)) begin
						if (row_q + YW'(2) >= h_eff) begin
							sc_q <= SC_DONE;
						end else begin
							row_q <= row_q + YW'(1);
							row_base_q <= row_base_q + AW'(w_eff);
							col_q <= '0;
							k_q <= '0;
							sc_q <= SC_RD_MID;
						end
					end else begin
						col_q <= col_q + CW'(1);
						sc_q <= SC_RD_MID;
					end
				end
				SC_DONE: sc_q <= SC_IDLE;
				default: sc_q <= SC_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

/* hdl/zst_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module zst_ctrl import zst_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic command,
	input wire logic cfg_write,
	input wire zst_sts_t sts,
	output zst_cmd_t cmd,
	output logic busy,
	output logic done,
	output logic last_pixel,
	output logic [15:0] rounds_done
);
	typedef enum logic [2:0] {
		ST_LOAD, ST_PASS1, ST_PASS2, ST_READ, ST_RDWAIT
	} state_t;

	state_t state_q;
	logic any_q;
	logic acc;

	assign acc = start && !busy;
	assign busy = (state_q == ST_PASS1) || (state_q == ST_PASS2) || (state_q == ST_RDWAIT);

	always_comb begin
		cmd = '0;
		cmd.write_px = acc && (command == CMD_LOAD) && (state_q == ST_LOAD);
		cmd.read_px = acc && (command == CMD_READ) && (state_q == ST_READ);
		cmd.pos_inc = cmd.write_px || cmd.read_px;
		cmd.pos_clear = cfg_write || (cmd.pos_inc && sts.pos_last);
		cmd.second = (state_q == ST_PASS2);
		cmd.scan_start = ((state_q == ST_PASS1) || (state_q == ST_PASS2)) && !sts.small_img;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			any_q <= 1'b0;
			done <= 1'b0;
			last_pixel <= 1'b0;
			rounds_done <= '0;
		end else begin
			done <= 1'b0;
			if (cfg_write) begin
				state_q <= ST_LOAD;
			end else begin
				case (state_q)
					ST_LOAD: begin
						if (cmd.write_px && sts.pos_last) begin
							rounds_done <= 16'd1;
							any_q <= 1'b0;
							state_q <= ST_PASS1;
						end
					end
					ST_PASS1: begin
						if (sts.small_img) begin
							state_q <= ST_READ;
						end else if (sts.scan_done) begin
							any_q <= sts.scan_any;
							state_q <= ST_PASS2;
						end
					end
					ST_PASS2: begin
						if (sts.scan_done) begin
							if (sts.scan_any || any_q) begin
								if (rounds_done != 16'hFFFF) rounds_done <= rounds_done + 16'd1;
								any_q <= 1'b0;
								state_q <= ST_PASS1;
							end else begin
								state_q <= ST_READ;
							end
						end
					end
					ST_READ: begin
						if (cmd.read_px) begin
							done <= 1'b1;
							last_pixel <= sts.pos_last;
							state_q <= ST_RDWAIT;
						end
					end
					ST_RDWAIT: begin
						state_q <= last_pixel ? ST_LOAD : ST_READ;
					end
					default: state_q <= ST_LOAD;
				endcase
			end
		end
	end
endmodule
`default_nettype wire

/* hdl/zhang_suen_thinning.sv */
`timescale 1ns / 1ps
`default_nettype none
// Zhang-Suen thinning engine for a binary image held in an on-chip frame memory.
// Commands are taken when start is high and busy is low. A load word (command 0)
// stores pixel_white at the next raster position, one per cycle; after the last
// pixel the block raises busy and thins the image in place, two sub-passes per
// round, until a round clears nothing; an image under three pixels wide or high
// is not thinned. Each sub-pass copies the first row to row history, read then
// write per pixel, then per interior pixel reads middle and below, waits, judges.
// A read word (command 1) returns one skeleton pixel in the next cycle on
// skeleton_pixel, with last_pixel and rounds_done, marked by done for one
// cycle; busy is high in that cycle, so reads do not overlap. The receiver
// cannot stall; every strobe must be taken. Reads while loading and loads
// while reading are dropped. A configuration write (cfg_valid and cfg_ready
// high; cfg_ready is low while busy) to image_width (index 0) or image_height
// (index 1) restarts loading.
// Reset returns to loading at position 0 with rounds_done zero; the frame
// memory is not cleared and needs no clearing pass.
module zhang_suen_thinning import zst_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic command,
	input wire logic pixel_white,
	output logic done,
	output logic skeleton_pixel,
	output logic last_pixel,
	output logic [15:0] rounds_done,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic cfg_index,
	input wire logic [9:0] cfg_data
);
	logic [9:0] width_q;
	logic [8:0] height_q;
	logic cfg_we;
	zst_cmd_t cmd;
	zst_sts_t sts;

	// Sizes stay fixed while thinning or a read is in flight.
	assign cfg_ready = !busy;
	assign cfg_we = cfg_valid && cfg_ready;

	// Register file for the two image size registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= RST_WIDTH;
			height_q <= RST_HEIGHT;
		end else if (cfg_we) begin
			if (cfg_index == REG_WIDTH) width_q <= cfg_data;
			else height_q <= cfg_data[8:0];
		end
	end

	zst_ctrl u_ctrl (
		.clk, .arst_n, .start, .command,
		.cfg_write(cfg_we), .sts, .cmd, .busy, .done, .last_pixel, .rounds_done
	);

	zst_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
		.clk, .arst_n, .image_width(width_q), .image_height(height_q),
		.pixel_white, .cmd, .sts, .skeleton_pixel
	);
endmodule
`default_nettype wire

/* hdl/zst_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module zst_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic command,
	input wire logic done,
	input wire logic [15:0] rounds_done
);
	// A result strobe never repeats in back-to-back cycles.
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done on consecutive cycles");
	// The block stays busy while a result is shown.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done without busy");
	// A result follows an accepted read word.
	a_done_read: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy && command)) else $error("done without read");
	// Rounds counter is at least one when a result is shown.
	a_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> rounds_done != 16'd0) else $error("zero rounds on result");
endmodule
bind zhang_suen_thinning zst_checker u_chk (
	.clk, .arst_n, .start, .busy, .command, .done, .rounds_done
);
`default_nettype wire
